[sv/lcd_pkg.sv]
// lcd_pkg: shared constants, register indexes and structs of the laplacian candidate detector
// no dependencies; used by every other file of the block but lcd_queue

package lcd_pkg;

   // default parameter values
   localparam int MAX_COLS_DEF = 1024;
   localparam int DIST_BITS_DEF = 16;

   // fixed field widths, minimum frame dimension and queue depth
   localparam int POS_W = 11;
   localparam int DIST_REQ_W = 16;
   localparam int FLOOR_W = 16;
   localparam int LAP_THR_W = 19;
   localparam int HALF_THR_W = 18;
   localparam int MIN_DIM = 3;
   localparam int QUEUE_DEPTH = 4;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register indexes, byte address is four times the index
   typedef enum logic [2:0] {
      REG_FRAME_COLS,
      REG_FRAME_ROWS,
      REG_COL_OFFSET,
      REG_ROW_OFFSET,
      REG_INNER_FLOOR,
      REG_LAP_THRESHOLD,
      REG_HALF_THRESHOLD
   } lcd_reg_type;

   // register file contents
   typedef struct packed {
      logic [POS_W-1:0]            frame_cols;
      logic [POS_W-1:0]            frame_rows;
      logic [POS_W-1:0]            col_offset;
      logic [POS_W-1:0]            row_offset;
      logic [FLOOR_W-1:0]          inner_floor;
      logic signed [LAP_THR_W-1:0] lap_threshold;
      logic signed [HALF_THR_W-1:0] half_threshold;
   } lcd_cfg_type;

   // per-item control that travels with the laplacian column through the queue
   typedef struct packed {
      logic             emit;
      logic             end_of_row;
      logic             end_of_frame;
      logic [POS_W-1:0] line_number;
      logic [POS_W-1:0] column;
   } lcd_tag_type;

endpackage

[sv/lcd_intf.sv]
// lcd_intf: valid/ready channel interfaces for the request and result streams
// depends on lcd_pkg for field widths

interface lcd_req_if;
   logic                           valid;
   logic                           ready;
   logic                           kind;
   logic [lcd_pkg::DIST_REQ_W-1:0] dist_req;

   modport source (output valid, kind, dist_req, input ready);
   modport sink (input valid, kind, dist_req, output ready);
endinterface

interface lcd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [lcd_pkg::POS_W-1:0] line_number;
   logic [lcd_pkg::POS_W-1:0] column;
   logic                      is_candidate;
   logic                      end_of_row;
   logic                      end_of_frame;

   modport source (output valid, line_number, column, is_candidate, end_of_row, end_of_frame,
                   input ready);
   modport sink (input valid, line_number, column, is_candidate, end_of_row, end_of_frame,
                 output ready);
endinterface

[sv/lcd_queue.sv]
// lcd_queue: small fifo between the laplacian front end and the candidate back end
// depends on nothing but its parameters

module lcd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic             nonempty,
   output logic [WIDTH-1:0] dout
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;

   assign full = (count_ff == CW'(DEPTH));
   assign nonempty = (count_ff != '0);
   assign dout = slot_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

[sv/lcd_front.sv]
// lcd_front: raster position, distance and laplacian line stores, laplacian of each pixel
// depends on lcd_pkg and lcd_intf; feeds one laplacian column per transfer into lcd_queue

module lcd_front #(
   parameter int MAX_COLS = lcd_pkg::MAX_COLS_DEF,
   parameter int DIST_BITS = lcd_pkg::DIST_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lcd_pkg::lcd_cfg_type        cfg,
   lcd_req_if.sink                     req,
   input  logic                        q_full,
   output logic                        q_push,
   output lcd_pkg::lcd_tag_type        q_tag,
   output logic [3*(DIST_BITS+3)-1:0]  q_lap
);

   localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int LAP_W = DIST_BITS + 3;
   localparam int PW = lcd_pkg::POS_W;

   // line stores: {row before, previous row}
   logic [2*DIST_BITS-1:0] dist_mem [MAX_COLS];
   logic [2*LAP_W-1:0]     lap_mem [MAX_COLS];

   logic [PW-1:0]          row_ff, col_ff;
   logic                   s1_valid_ff;
   logic [PW-1:0]          s1_row_ff, s1_col_ff;
   logic [DIST_BITS-1:0]   s1_x_ff, left_ff;
   logic [2*DIST_BITS-1:0] dist_rd_a_ff;
   logic [DIST_BITS-1:0]   dist_rd_b_ff;
   logic [2*LAP_W-1:0]     lap_rd_ff;

   logic [PW-1:0]          cols, rows, cur_row, cur_col, row_in, col_in;
   logic [PW:0]            row_inc, col_inc;
   logic [PW:0]            col_p1;
   logic [AW-1:0]          addr_a, addr_b, wr_addr;
   logic                   restart, accept, lap_en;
   logic [31:0]            dist_ext;
   logic [DIST_BITS-1:0]   x, up, up2, right;
   logic [LAP_W-1:0]       sum, v, lap0, lap1;

   // effective frame size
   always_comb begin
      if (cfg.frame_cols < PW'(lcd_pkg::MIN_DIM)) begin
         cols = PW'(lcd_pkg::MIN_DIM);
      end else if (32'(cfg.frame_cols) > 32'(MAX_COLS)) begin
         cols = PW'(MAX_COLS);
      end else begin
         cols = cfg.frame_cols;
      end
      if (cfg.frame_rows < PW'(lcd_pkg::MIN_DIM)) begin
         rows = PW'(lcd_pkg::MIN_DIM);
      end else begin
         rows = cfg.frame_rows;
      end
   end

   // raster position of the incoming item, restarting if outside frame plus flush row
   assign restart = (col_ff >= cols) || (row_ff > rows);
   assign cur_row = restart ? '0 : row_ff;
   assign cur_col = restart ? '0 : col_ff;
   assign col_inc = {1'b0, cur_col} + 1'b1;
   assign row_inc = {1'b0, cur_row} + 1'b1;

   always_comb begin
      col_in = col_inc[PW-1:0];
      row_in = cur_row;
      if (col_inc >= {1'b0, cols}) begin
         col_in = '0;
         row_in = (row_inc > {1'b0, rows}) ? '0 : row_inc[PW-1:0];
      end
   end

   assign req.ready = !s1_valid_ff || !q_full;
   assign accept = req.valid && req.ready;
   assign q_push = s1_valid_ff && !q_full;

   assign dist_ext = 32'(req.dist_req);
   assign x = req.kind ? '0 : dist_ext[DIST_BITS-1:0];

   // read addresses: this column and the one to its right
   assign addr_a = AW'(cur_col);
   assign col_p1 = (32'(col_inc) == 32'(MAX_COLS)) ? '0 : col_inc;
   assign addr_b = AW'(col_p1);
   assign wr_addr = AW'(s1_col_ff);

   // position and stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         s1_valid_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (q_push) begin
            s1_valid_ff <= 1'b0;
         end
         if (q_push) begin
            left_ff <= up;
         end
      end
   end

   // stage payload and line store reads
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_ff <= cur_row;
         s1_col_ff <= cur_col;
         s1_x_ff <= x;
         dist_rd_a_ff <= dist_mem[addr_a];
         dist_rd_b_ff <= dist_mem[addr_b][DIST_BITS-1:0];
         lap_rd_ff <= lap_mem[addr_a];
      end
   end

   // line store updates as the item leaves the stage
   always_ff @(posedge clock) begin
      if (q_push) begin
         dist_mem[wr_addr] <= {up, s1_x_ff};
         lap_mem[wr_addr] <= {lap0, v};
      end
   end

   // 4-neighbour laplacian of the pixel one row up, clamped to non-positive
   assign up = dist_rd_a_ff[DIST_BITS-1:0];
   assign up2 = dist_rd_a_ff[2*DIST_BITS-1:DIST_BITS];
   assign right = dist_rd_b_ff;
   assign lap0 = lap_rd_ff[LAP_W-1:0];
   assign lap1 = lap_rd_ff[2*LAP_W-1:LAP_W];

   assign lap_en = (s1_row_ff >= PW'(2)) && (s1_row_ff <= rows - 1'b1)
                   && (s1_col_ff >= PW'(1))
                   && (({1'b0, s1_col_ff} + (PW+1)'(2)) <= {1'b0, cols})
                   && (32'(up) > 32'(cfg.inner_floor));
   assign sum = LAP_W'(up2) + LAP_W'(s1_x_ff) + LAP_W'(left_ff) + LAP_W'(right)
                - (LAP_W'(up) << 2);
   assign v = (lap_en && sum[LAP_W-1]) ? sum : '0;

   assign q_lap = {lap1, lap0, v};

   // result tag for the pixel at the window centre
   always_comb begin
      q_tag.emit = (s1_row_ff >= PW'(3)) && (s1_col_ff >= PW'(2));
      q_tag.end_of_row = (s1_col_ff == cols - 1'b1);
      q_tag.end_of_frame = (s1_col_ff == cols - 1'b1) && (s1_row_ff == rows);
      q_tag.line_number = cfg.row_offset + s1_row_ff - PW'(4);
      q_tag.column = s1_col_ff - 1'b1 + cfg.col_offset;
   end

endmodule

[sv/lcd_back.sv]
// lcd_back: 3x3 laplacian window, candidate test and result register
// depends on lcd_pkg and lcd_intf; drains laplacian columns from lcd_queue

module lcd_back #(
   parameter int DIST_BITS = lcd_pkg::DIST_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lcd_pkg::lcd_cfg_type        cfg,
   input  logic                        q_nonempty,
   input  lcd_pkg::lcd_tag_type        q_tag,
   input  logic [3*(DIST_BITS+3)-1:0]  q_lap,
   output logic                        q_pop,
   lcd_rsp_if.source                   rsp
);

   localparam int LAP_W = DIST_BITS + 3;
   localparam int CMP_W = (LAP_W > lcd_pkg::LAP_THR_W) ? LAP_W : lcd_pkg::LAP_THR_W;
   localparam int PW = lcd_pkg::POS_W;

   logic signed [LAP_W-1:0] win_ff [9];
   logic signed [LAP_W-1:0] win_in [9];
   logic signed [CMP_W-1:0] lap_thr, half_thr, ctr;
   logic [7:0]              below;
   logic [3:0]              cnt;
   logic                    cand;

   logic                    valid_ff, cand_ff, eor_ff, eof_ff;
   logic [PW-1:0]           line_ff, column_ff;

   assign q_pop = q_nonempty && (!valid_ff || rsp.ready);

   // window shifted by one column: rows top to bottom, columns left to right
   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = q_lap[3*LAP_W-1:2*LAP_W];
      win_in[3] = win_ff[4];
      win_in[4] = win_ff[5];
      win_in[5] = q_lap[2*LAP_W-1:LAP_W];
      win_in[6] = win_ff[7];
      win_in[7] = win_ff[8];
      win_in[8] = q_lap[LAP_W-1:0];
   end

   // candidate test on the shifted window
   assign lap_thr = CMP_W'(cfg.lap_threshold);
   assign half_thr = CMP_W'(cfg.half_threshold);
   assign ctr = CMP_W'(win_in[4]);

   always_comb begin
      below[0] = CMP_W'(win_in[0]) < half_thr;
      below[1] = CMP_W'(win_in[1]) < half_thr;
      below[2] = CMP_W'(win_in[2]) < half_thr;
      below[3] = CMP_W'(win_in[3]) < half_thr;
      below[4] = CMP_W'(win_in[5]) < half_thr;
      below[5] = CMP_W'(win_in[6]) < half_thr;
      below[6] = CMP_W'(win_in[7]) < half_thr;
      below[7] = CMP_W'(win_in[8]) < half_thr;
      cnt = '0;
      for (int k = 0; k < 8; k++) begin
         cnt = cnt + 4'(below[k]);
      end
      cand = (ctr < lap_thr) || ((ctr < half_thr) && (cnt >= 4'd4));
   end

   // window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else if (q_pop) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= q_tag.emit;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_tag.emit) begin
         line_ff <= q_tag.line_number;
         column_ff <= q_tag.column;
         cand_ff <= cand;
         eor_ff <= q_tag.end_of_row;
         eof_ff <= q_tag.end_of_frame;
      end
   end

   assign rsp.valid = valid_ff;
   assign rsp.line_number = line_ff;
   assign rsp.column = column_ff;
   assign rsp.is_candidate = cand_ff;
   assign rsp.end_of_row = eor_ff;
   assign rsp.end_of_frame = eof_ff;

endmodule

[sv/laplacian_candidate_detector_core.sv]
// Laplacian ridge-point detector: one pixel transfer per cycle while the queue has room, one
// result per inner pixel, made from item (i+2,j+1) for pixel (i,j). Throughput: 1 item per
// cycle with room in the queue, set by one line store read and write per item in lcd_front.
// Reset: synchronous, active high; clears position, pipeline, queue and window, loads
// register defaults. Line stores are not cleared; each entry is written before it is used.

module laplacian_candidate_detector_core #(
   parameter int MAX_COLS = lcd_pkg::MAX_COLS_DEF,
   parameter int DIST_BITS = lcd_pkg::DIST_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   lcd_req_if.sink                         req_ch,
   lcd_rsp_if.source                       rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lcd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lcd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lcd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int LAP_W = DIST_BITS + 3;
   localparam int QW = $bits(lcd_pkg::lcd_tag_type) + 3 * LAP_W;

   lcd_pkg::lcd_cfg_type cfg_ff;
   lcd_pkg::lcd_tag_type push_tag, pop_tag;
   logic [3*LAP_W-1:0]   push_lap, pop_lap;
   logic [QW-1:0]        q_dout;
   logic                 q_push, q_pop, q_full, q_nonempty, csr_wr;
   logic [2:0]           csr_idx;

   // register file
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_cols <= 11'd1024;
         cfg_ff.frame_rows <= 11'd1024;
         cfg_ff.col_offset <= 11'd0;
         cfg_ff.row_offset <= 11'd2;
         cfg_ff.inner_floor <= 16'd128;
         cfg_ff.lap_threshold <= -19'sd64;
         cfg_ff.half_threshold <= -18'sd32;
      end else if (csr_wr) begin
         case (csr_idx)
            lcd_pkg::REG_FRAME_COLS: begin
               cfg_ff.frame_cols <= csr_pwdata[lcd_pkg::POS_W-1:0];
            end
            lcd_pkg::REG_FRAME_ROWS: begin
               cfg_ff.frame_rows <= csr_pwdata[lcd_pkg::POS_W-1:0];
            end
            lcd_pkg::REG_COL_OFFSET: begin
               cfg_ff.col_offset <= csr_pwdata[lcd_pkg::POS_W-1:0];
            end
            lcd_pkg::REG_ROW_OFFSET: begin
               cfg_ff.row_offset <= csr_pwdata[lcd_pkg::POS_W-1:0];
            end
            lcd_pkg::REG_INNER_FLOOR: begin
               cfg_ff.inner_floor <= csr_pwdata[lcd_pkg::FLOOR_W-1:0];
            end
            lcd_pkg::REG_LAP_THRESHOLD: begin
               cfg_ff.lap_threshold <= csr_pwdata[lcd_pkg::LAP_THR_W-1:0];
            end
            lcd_pkg::REG_HALF_THRESHOLD: begin
               cfg_ff.half_threshold <= csr_pwdata[lcd_pkg::HALF_THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_idx)
         lcd_pkg::REG_FRAME_COLS: csr_prdata = 32'(cfg_ff.frame_cols);
         lcd_pkg::REG_FRAME_ROWS: csr_prdata = 32'(cfg_ff.frame_rows);
         lcd_pkg::REG_COL_OFFSET: csr_prdata = 32'(cfg_ff.col_offset);
         lcd_pkg::REG_ROW_OFFSET: csr_prdata = 32'(cfg_ff.row_offset);
         lcd_pkg::REG_INNER_FLOOR: csr_prdata = 32'(cfg_ff.inner_floor);
         lcd_pkg::REG_LAP_THRESHOLD: csr_prdata = 32'($unsigned(cfg_ff.lap_threshold));
         lcd_pkg::REG_HALF_THRESHOLD: csr_prdata = 32'($unsigned(cfg_ff.half_threshold));
         default: csr_prdata = '0;
      endcase
   end

   // front end: position, line stores, laplacian
   lcd_front #(
      .MAX_COLS  (MAX_COLS),
      .DIST_BITS (DIST_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req    (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_tag  (push_tag),
      .q_lap  (push_lap)
   );

   // decoupling queue
   lcd_queue #(
      .WIDTH (QW),
      .DEPTH (lcd_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .din      ({push_tag, push_lap}),
      .full     (q_full),
      .pop      (q_pop),
      .nonempty (q_nonempty),
      .dout     (q_dout)
   );

   assign pop_tag = lcd_pkg::lcd_tag_type'(q_dout[QW-1:3*LAP_W]);
   assign pop_lap = q_dout[3*LAP_W-1:0];

   // back end: window, candidate test, result register
   lcd_back #(
      .DIST_BITS (DIST_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_nonempty (q_nonempty),
      .q_tag      (pop_tag),
      .q_lap      (pop_lap),
      .q_pop      (q_pop),
      .rsp        (rsp_ch)
   );

endmodule

[bench/tb.sv]
// tb: self-checking bench for laplacian_candidate_detector_core, raster frames in, points out
// depends on lcd_pkg, lcd_req_if and lcd_rsp_if; holds its own pixel-level predictor

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_COLS = 1024;
   localparam int IDLE_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 12;

   typedef struct packed {
      bit [lcd_pkg::POS_W-1:0] line_number;
      bit [lcd_pkg::POS_W-1:0] column;
      bit                      is_candidate;
      bit                      end_of_row;
      bit                      end_of_frame;
   } ridge_point_type;

   // pixel-level predictor of the detector plus the queue of predicted points
   class lcd_scoreboard_type;
      bit [lcd_pkg::POS_W-1:0] cols_reg, rows_reg, coff, roff;
      bit [15:0]      floor_reg;
      longint         lap_thr, half_thr;
      bit [15:0]      dist_prev[STORE_COLS], dist_prev2[STORE_COLS];
      longint         lap_prev[STORE_COLS], lap_prev2[STORE_COLS];
      longint         win[10];
      int             row_pos, col_pos;
      ridge_point_type pending_points[$];
      int             errors;

      function new();
         cols_reg = 1024; rows_reg = 1024; coff = 0; roff = 2;
         floor_reg = 128; lap_thr = -64; half_thr = -32;
         foreach (dist_prev[i]) begin
            dist_prev[i] = 0; dist_prev2[i] = 0; lap_prev[i] = 0; lap_prev2[i] = 0;
         end
         foreach (win[i]) win[i] = 0;
         row_pos = 0; col_pos = 0; errors = 0;
      endfunction

      function void report(string msg);
         $display("error at %0t: %s", $time, msg);
         errors++;
      endfunction

      function int frame_width();
         return cols_reg < lcd_pkg::MIN_DIM ? lcd_pkg::MIN_DIM
            : (cols_reg > STORE_COLS ? STORE_COLS : cols_reg);
      endfunction

      function int frame_height();
         return rows_reg < lcd_pkg::MIN_DIM ? lcd_pkg::MIN_DIM
            : (rows_reg > 2047 ? 2047 : rows_reg);
      endfunction

      function void write_reg(lcd_pkg::lcd_reg_type idx, bit [31:0] val);
         logic signed [lcd_pkg::LAP_THR_W-1:0]  lt;
         logic signed [lcd_pkg::HALF_THR_W-1:0] ht;
         lt = val[lcd_pkg::LAP_THR_W-1:0];
         ht = val[lcd_pkg::HALF_THR_W-1:0];
         case (idx)
            lcd_pkg::REG_FRAME_COLS: cols_reg = val[lcd_pkg::POS_W-1:0];
            lcd_pkg::REG_FRAME_ROWS: rows_reg = val[lcd_pkg::POS_W-1:0];
            lcd_pkg::REG_COL_OFFSET: coff = val[lcd_pkg::POS_W-1:0];
            lcd_pkg::REG_ROW_OFFSET: roff = val[lcd_pkg::POS_W-1:0];
            lcd_pkg::REG_INNER_FLOOR: floor_reg = val[15:0];
            lcd_pkg::REG_LAP_THRESHOLD: lap_thr = lt;
            lcd_pkg::REG_HALF_THRESHOLD: half_thr = ht;
            default: ;
         endcase
      endfunction

      // one accepted pixel: update windows and line stores, maybe predict a point
      function void note_pixel(bit kind, bit [15:0] sample);
         int ec, er, r, c, pr, pc, cnt, t;
         longint x, up, up2, s, v, ctr;
         bit cand;
         ridge_point_type p;
         ec = frame_width();
         er = frame_height();
         if (col_pos >= ec || row_pos > er) begin
            col_pos = 0; row_pos = 0;
         end
         r = row_pos; c = col_pos;
         x = kind ? 0 : sample;
         up = dist_prev[c];
         up2 = dist_prev2[c];
         v = 0;
         // laplacian of the pixel one row up
         if (r >= 2 && r <= er - 1 && c >= 1 && c + 2 <= ec && up > floor_reg) begin
            s = up2 + x + win[9] + dist_prev[(c + 1) % STORE_COLS] - 4 * up;
            v = s > 0 ? 0 : s;
         end
         for (int k = 0; k < 3; k++) begin
            win[k*3] = win[k*3+1];
            win[k*3+1] = win[k*3+2];
         end
         win[2] = lap_prev2[c];
         win[5] = lap_prev[c];
         win[8] = v;
         // candidate test on the window center
         if (r >= 3 && c >= 2) begin
            ctr = win[4];
            pr = r - 2; pc = c - 1;
            if (ctr < lap_thr) cand = 1;
            else if (ctr >= half_thr) cand = 0;
            else begin
               cnt = 0;
               for (int k = 0; k < 9; k++)
                  if (k != 4 && win[k] < half_thr) cnt++;
               cand = cnt >= 4;
            end
            t = roff + pr - 2;
            p.line_number = t[lcd_pkg::POS_W-1:0];
            t = pc + coff;
            p.column = t[lcd_pkg::POS_W-1:0];
            p.is_candidate = cand;
            p.end_of_row = pc == ec - 2;
            p.end_of_frame = pc == ec - 2 && pr == er - 2;
            pending_points.push_back(p);
         end
         lap_prev2[c] = lap_prev[c];
         lap_prev[c] = v;
         dist_prev2[c] = up;
         dist_prev[c] = x;
         win[9] = up;
         col_pos = c + 1;
         if (col_pos >= ec) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos > er) row_pos = 0;
         end
      endfunction

      function void check_point(ridge_point_type got);
         ridge_point_type e;
         if (pending_points.size() == 0) begin
            report($sformatf("unexpected point line %0d col %0d", got.line_number, got.column));
            return;
         end
         e = pending_points.pop_front();
         if (got != e)
            report($sformatf(
               "got line %0d col %0d cand %0d eor %0d eof %0d, want %0d %0d %0d %0d %0d",
               got.line_number, got.column, got.is_candidate, got.end_of_row, got.end_of_frame,
               e.line_number, e.column, e.is_candidate, e.end_of_row, e.end_of_frame));
      endfunction
   endclass

   logic clock, reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [lcd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [lcd_pkg::CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;
   lcd_req_if req_ch();
   lcd_rsp_if rsp_ch();

   lcd_scoreboard_type sb;
   bit calm, hold_req;
   int idle_cycles, pixels_sent;

   laplacian_candidate_detector_core uut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #1 clock = ~clock;

   initial begin
      clock = 0; reset = 1;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      req_ch.valid = 0; req_ch.kind = 0; req_ch.dist_req = '0;
      rsp_ch.ready = 0;
      calm = 0; hold_req = 0; idle_cycles = 0; pixels_sent = 0;
      sb = new();
   end

   // monitor: note input transfers and check result transfers
   always @(posedge clock) begin
      ridge_point_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) sb.note_pixel(req_ch.kind, req_ch.dist_req);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.line_number = rsp_ch.line_number;
            got.column = rsp_ch.column;
            got.is_candidate = rsp_ch.is_candidate;
            got.end_of_row = rsp_ch.end_of_row;
            got.end_of_frame = rsp_ch.end_of_frame;
            sb.check_point(got);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // receiver: random stalls, a calm stretch, and one long hold-off
   always begin
      @(posedge clock);
      if (hold_req) begin
         rsp_ch.ready <= 0;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_req = 0;
      end else begin
         rsp_ch.ready <= calm || $urandom_range(0, 99) >= 18;
      end
   end

   task csr_write(lcd_pkg::lcd_reg_type idx, bit [31:0] val);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      sb.write_reg(idx, val);
   endtask

   task wait_drain();
      while (sb.pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one pixel transfer, with a random one-cycle gap before it
   task send_pixel(bit kind, bit [15:0] sample);
      if (!calm && $urandom_range(0, 99) < 18) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1; req_ch.kind <= kind; req_ch.dist_req <= sample;
      do @(posedge clock); while (!req_ch.ready);
      pixels_sent++;
   endtask

   // program all registers while idle
   task setup_frame(int nc, int nr, int co, int ro, int fl, int lt, int ht);
      wait_drain();
      csr_write(lcd_pkg::REG_FRAME_COLS, nc);
      csr_write(lcd_pkg::REG_FRAME_ROWS, nr);
      csr_write(lcd_pkg::REG_COL_OFFSET, co);
      csr_write(lcd_pkg::REG_ROW_OFFSET, ro);
      csr_write(lcd_pkg::REG_INNER_FLOOR, fl);
      csr_write(lcd_pkg::REG_LAP_THRESHOLD, lt);
      csr_write(lcd_pkg::REG_HALF_THRESHOLD, ht);
   endtask

   // one frame plus its flush row; style 0 full random, 1 mid-range ridges, 2 extremes
   task run_frame(int style);
      int ec, er, n;
      bit kind;
      bit [15:0] d;
      ec = sb.frame_width();
      er = sb.frame_height();
      n = 0;
      for (int r = 0; r <= er; r++)
         for (int c = 0; c < ec; c++) begin
            kind = $urandom_range(0, 99) < 6;
            case (style)
               0: d = 16'($urandom());
               1: d = 16'($urandom_range(100, 500));
               default: begin
                  case (n % 6)
                     0: d = 16'hFFFF;
                     1: d = 16'h0000;
                     2: d = 16'h0001;
                     3: d = 16'h8000;
                     4: d = 16'h7FFF;
                     default: d = 16'hAAAA;
                  endcase
                  kind = n % 7 == 5;
               end
            endcase
            if (r == er) kind = 1'($urandom_range(0, 1));
            send_pixel(kind, d);
            n++;
         end
      req_ch.valid <= 0;
   endtask

   initial begin
      int ph;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: default settings on a small frame, zero thresholds, wrapped offsets, clamps
      setup_frame(3, 3, 0, 2, 128, -64, -32);
      run_frame(2);
      setup_frame(4, 5, 1024, 0, 0, 0, 0);
      run_frame(2);
      setup_frame(0, 2, 1023, 1, 65535, -262140, -131070);
      run_frame(0);

      // random frames, mostly small
      ph = 0;
      while (pixels_sent < 720) begin
         setup_frame($urandom_range(3, 14), $urandom_range(3, 10), $urandom_range(0, 1024),
            $urandom_range(0, 1024), $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535)
            : $urandom_range(0, 400),
            $urandom_range(0, 9) == 0 ? -$urandom_range(0, 262140) : -$urandom_range(0, 3000),
            $urandom_range(0, 9) == 0 ? -$urandom_range(0, 131070) : -$urandom_range(0, 1500));
         calm = ph % 9 == 4;
         if (ph == 3) hold_req = 1;
         run_frame($urandom_range(0, 3) == 0 ? 0 : 1);
         calm = 0;
         ph++;
      end

      // wide frame and out-of-range sizes
      setup_frame(40, 3, 1024, 1024, 300, -100, -50);
      run_frame(1);
      setup_frame(0, 40, 5, 7, 150, -262140, -131070);
      run_frame(1);

      wait_drain();
      if (sb.pending_points.size() != 0) sb.report("points still expected at end");
      if (sb.errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
